// ===== rtl/ipfc_pkg.sv =====
`default_nettype none

package ipfc_pkg;

  localparam int TableEntriesDef = 32;
  localparam int MinHeaderBytes = 20;
  localparam int ReadableEntries = 1 << 5;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_HIT         = 3'd1,
    ST_BAD_HEADER  = 3'd2,
    ST_FULL        = 3'd3,
    ST_READ_OK     = 3'd4,
    ST_READ_UNUSED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_HOLD
  } fsm_t;

  // One item as it walks down the row of cells.
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic        found;
    status_t     status;
    logic [4:0]  index;
    logic [31:0] count;
    logic [31:0] ip_dest;
    logic [31:0] ip_src;
    logic [47:0] mac_dst;
    logic [47:0] mac_src;
    logic [4:0]  read_index;
  } carrier_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  entry_index;
    logic [31:0] packet_count;
    logic [31:0] entry_ip_dest;
    logic [31:0] entry_ip_src;
    logic [47:0] entry_mac_dst;
    logic [47:0] entry_mac_src;
    logic [5:0]  entries_in_use;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/ipfc_if.sv =====
`default_nettype none

interface ipfc_req_if import ipfc_pkg::*; ();
  logic        valid;
  logic        ready;
  op_t         operation;
  logic [47:0] mac_dst;
  logic [47:0] mac_src;
  logic [3:0]  header_length_words;
  logic [31:0] ip_dest;
  logic [31:0] ip_src;
  logic [4:0]  read_index;

  modport source (
    output valid, operation, mac_dst, mac_src, header_length_words, ip_dest, ip_src,
    read_index,
    input  ready
  );
  modport sink (
    input  valid, operation, mac_dst, mac_src, header_length_words, ip_dest, ip_src,
    read_index,
    output ready
  );
endinterface

interface ipfc_rsp_if import ipfc_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [4:0]  entry_index;
  logic [31:0] packet_count;
  logic [31:0] entry_ip_dest;
  logic [31:0] entry_ip_src;
  logic [47:0] entry_mac_dst;
  logic [47:0] entry_mac_src;
  logic [5:0]  entries_in_use;

  modport source (
    output valid, status, entry_index, packet_count, entry_ip_dest, entry_ip_src,
    entry_mac_dst, entry_mac_src, entries_in_use,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, packet_count, entry_ip_dest, entry_ip_src,
    entry_mac_dst, entry_mac_src, entries_in_use,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ipfc_cell.sv =====
`default_nettype none

module ipfc_cell import ipfc_pkg::*; #(
  parameter int CELL_INDEX = 0,
  parameter int USED_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [USED_W-1:0] used,
  input  carrier_t          carrier_in,
  output carrier_t          carrier_out
);

  localparam logic [USED_W-1:0] Pos = USED_W'(CELL_INDEX);
  localparam bit Readable = CELL_INDEX < ReadableEntries;

  logic [31:0] ip_dest;
  logic [31:0] ip_src;
  logic [47:0] mac_dst;
  logic [47:0] mac_src;
  logic [31:0] count;

  logic        filled;
  logic        live;
  logic        hit;
  logic        insert;
  logic        read;
  logic [31:0] count_up;
  carrier_t    carrier_next;

  always_comb begin
    filled   = Pos < used;
    live     = carrier_in.valid && !carrier_in.found;
    hit      = live && carrier_in.op == OP_RECORD && filled &&
               ip_dest == carrier_in.ip_dest && ip_src == carrier_in.ip_src;
    insert   = live && carrier_in.op == OP_RECORD && Pos == used;
    read     = live && carrier_in.op == OP_READ && Readable && filled &&
               carrier_in.read_index == 5'(CELL_INDEX);
    count_up = (count == CountMax) ? count : count + 32'd1;

    carrier_next = carrier_in;
    priority if (hit) begin
      carrier_next.found    = 1'b1;
      carrier_next.status   = ST_HIT;
      carrier_next.index    = 5'(CELL_INDEX);
      carrier_next.count    = count_up;
      carrier_next.mac_dst  = mac_dst;
      carrier_next.mac_src  = mac_src;
    end else if (insert) begin
      carrier_next.found  = 1'b1;
      carrier_next.status = ST_INSERTED;
      carrier_next.index  = 5'(CELL_INDEX);
      carrier_next.count  = 32'd1;
    end else if (read) begin
      carrier_next.found    = 1'b1;
      carrier_next.status   = ST_READ_OK;
      carrier_next.index    = 5'(CELL_INDEX);
      carrier_next.count    = count;
      carrier_next.ip_dest  = ip_dest;
      carrier_next.ip_src   = ip_src;
      carrier_next.mac_dst  = mac_dst;
      carrier_next.mac_src  = mac_src;
    end else begin
      carrier_next = carrier_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_out.valid <= 1'b0;
    end else begin
      carrier_out <= carrier_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && hit) begin
      count <= count_up;
    end else if (!rst && insert) begin
      ip_dest  <= carrier_in.ip_dest;
      ip_src   <= carrier_in.ip_src;
      mac_dst  <= carrier_in.mac_dst;
      mac_src  <= carrier_in.mac_src;
      count    <= 32'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ip_pair_flow_counter.sv =====
`default_nettype none

// Packet counter over an exact-match flow table keyed by the IPv4 address pair. The table is a
// row of TABLE_ENTRIES cells, one flow each; an item enters cell 0 in the cycle it is accepted
// and moves one cell per clock, so a hit, an append, a read or a miss is settled as it passes.
// Each result passes through the TABLE_ENTRIES cell registers, and the hold register when the
// output is busy, into the response register; one item is in the row at a time, so a new item
// is taken only once the last result sits in the response register, where it may still wait
// to be drained. Table contents need no clearing after reset; only the fill count is reset.

module ip_pair_flow_counter import ipfc_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input logic        clk,
  input logic        rst,
  ipfc_req_if.sink   request,
  ipfc_rsp_if.source response
);

  localparam int UsedW = $clog2(TABLE_ENTRIES + 1);

  carrier_t link [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] chain_valid;

  fsm_t       state;
  fsm_t       state_next;
  logic [UsedW-1:0] used;
  logic [UsedW-1:0] used_next;
  logic       out_free;
  logic       take_tail;
  logic       park_tail;
  logic       take_hold;
  logic       tail_empty;
  carrier_t   tail;
  result_t    tail_result;
  result_t    hold;
  result_t    rsp;
  logic       rsp_valid;

  always_comb begin
    link[0].valid      = request.valid && request.ready;
    link[0].op         = request.operation;
    link[0].found      = request.operation == OP_RECORD &&
                         {request.header_length_words, 2'b00} < 6'(MinHeaderBytes);
    link[0].status     = ST_BAD_HEADER;
    link[0].index      = 5'd0;
    link[0].count      = 32'd0;
    link[0].ip_dest    = request.ip_dest;
    link[0].ip_src     = request.ip_src;
    link[0].mac_dst    = request.mac_dst;
    link[0].mac_src    = request.mac_src;
    link[0].read_index = request.read_index;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_row
    ipfc_cell #(
      .CELL_INDEX(i),
      .USED_W    (UsedW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .used       (used),
      .carrier_in (link[i]),
      .carrier_out(link[i+1])
    );
    assign chain_valid[i] = link[i+1].valid;
  end

  assign tail = link[TABLE_ENTRIES];

  always_comb begin
    tail_result.status = tail.found ? tail.status :
                         (tail.op == OP_READ ? ST_READ_UNUSED : ST_FULL);
    tail_empty = !tail.found || tail.status == ST_BAD_HEADER;
    used_next  = (tail.valid && tail_result.status == ST_INSERTED) ? used + 1'b1 : used;
    tail_result.entry_index    = tail_empty ? 5'd0 : tail.index;
    tail_result.packet_count   = tail_empty ? 32'd0 : tail.count;
    tail_result.entry_ip_dest  = tail_empty ? 32'd0 : tail.ip_dest;
    tail_result.entry_ip_src   = tail_empty ? 32'd0 : tail.ip_src;
    tail_result.entry_mac_dst  = tail_empty ? 48'd0 : tail.mac_dst;
    tail_result.entry_mac_src  = tail_empty ? 48'd0 : tail.mac_src;
    tail_result.entries_in_use = 6'(used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
  end

  always_comb begin
    out_free      = !rsp_valid || response.ready;
    state_next    = state;
    request.ready = 1'b0;
    take_tail     = 1'b0;
    park_tail     = 1'b0;
    take_hold     = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        request.ready = 1'b1;
        if (request.valid) begin
          state_next = FSM_RUN;
        end
      end
      FSM_RUN: begin
        if (tail.valid) begin
          if (out_free) begin
            take_tail  = 1'b1;
            state_next = FSM_IDLE;
          end else begin
            park_tail  = 1'b1;
            state_next = FSM_HOLD;
          end
        end
      end
      FSM_HOLD: begin
        if (out_free) begin
          take_hold  = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take_tail || take_hold) begin
      rsp_valid <= 1'b1;
    end else if (response.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_tail) begin
      rsp <= tail_result;
    end else if (take_hold) begin
      rsp <= hold;
    end
    if (park_tail) begin
      hold <= tail_result;
    end
  end

  assign response.valid          = rsp_valid;
  assign response.status         = rsp.status;
  assign response.entry_index    = rsp.entry_index;
  assign response.packet_count   = rsp.packet_count;
  assign response.entry_ip_dest  = rsp.entry_ip_dest;
  assign response.entry_ip_src   = rsp.entry_ip_src;
  assign response.entry_mac_dst  = rsp.entry_mac_dst;
  assign response.entry_mac_src  = rsp.entry_mac_src;
  assign response.entries_in_use = rsp.entries_in_use;

  a_one_item_in_row: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one item in the row of cells");

  a_tail_only_when_running: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> state == FSM_RUN)
    else $error("item left the row while no item was in flight");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= UsedW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_insert_grows_fill: assert property (@(posedge clk) disable iff (rst)
    tail.valid && tail_result.status == ST_INSERTED |=> used == UsedW'($past(used) + 1'b1))
    else $error("append did not grow the fill count by one");

  a_hold_has_output: assert property (@(posedge clk) disable iff (rst)
    state == FSM_HOLD |-> rsp_valid)
    else $error("parked result while the response register is empty");

endmodule

`default_nettype wire

// ===== tb/ip_pair_flow_counter_tb.sv =====
`timescale 1ns / 1ps

module ip_pair_flow_counter_tb;
  import ipfc_pkg::*;

  localparam int Entries = TableEntriesDef;
  localparam int ClkPeriod = 20;
  localparam int ItemCycles = Entries + 1;

  typedef struct {
    op_t         op;
    logic [47:0] mac_dst;
    logic [47:0] mac_src;
    logic [3:0]  ihl;
    logic [31:0] ip_dest;
    logic [31:0] ip_src;
    logic [4:0]  read_index;
  } flow_req_t;

  logic clk;
  logic rst;

  ipfc_req_if request_if ();
  ipfc_rsp_if response_if ();

  ip_pair_flow_counter u_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_if),
    .response (response_if)
  );

  // Flow table as the testbench expects the block to hold it.
  logic [31:0] tbl_ip_dest [Entries];
  logic [31:0] tbl_ip_src [Entries];
  logic [47:0] tbl_mac_dst [Entries];
  logic [47:0] tbl_mac_src [Entries];
  logic [31:0] tbl_count [Entries];
  int          tbl_fill = 0;

  result_t expected_results [$];
  int      errors = 0;
  int      items_sent = 0;
  int      status_seen [6] = '{default: 0};
  int      src_idle_pct = 15;
  int      sink_idle_pct = 15;
  int      sink_hold_cycles = 0;

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  function automatic result_t predict_flow_result(flow_req_t r);
    result_t res;
    int      slot;
    res = '0;
    slot = -1;
    if (r.op == OP_READ) begin
      if (r.read_index < tbl_fill) begin
        res.status = ST_READ_OK;
        slot = r.read_index;
      end else begin
        res.status = ST_READ_UNUSED;
      end
    end else if (int'(r.ihl) * 4 < MinHeaderBytes) begin
      res.status = ST_BAD_HEADER;
    end else begin
      for (int i = 0; i < tbl_fill; i++) begin
        if (slot < 0 && tbl_ip_dest[i] == r.ip_dest && tbl_ip_src[i] == r.ip_src) slot = i;
      end
      if (slot >= 0) begin
        if (tbl_count[slot] != CountMax) tbl_count[slot] = tbl_count[slot] + 1;
        res.status = ST_HIT;
      end else if (tbl_fill >= Entries) begin
        res.status = ST_FULL;
      end else begin
        slot = tbl_fill;
        tbl_ip_dest[slot] = r.ip_dest;
        tbl_ip_src[slot] = r.ip_src;
        tbl_mac_dst[slot] = r.mac_dst;
        tbl_mac_src[slot] = r.mac_src;
        tbl_count[slot] = 32'd1;
        tbl_fill++;
        res.status = ST_INSERTED;
      end
    end
    if (slot >= 0) begin
      res.entry_index = slot[4:0];
      res.packet_count = tbl_count[slot];
      res.entry_ip_dest = tbl_ip_dest[slot];
      res.entry_ip_src = tbl_ip_src[slot];
      res.entry_mac_dst = tbl_mac_dst[slot];
      res.entry_mac_src = tbl_mac_src[slot];
    end
    res.entries_in_use = tbl_fill[5:0];
    return res;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic flow_req_t packet(logic [3:0] ihl, logic [31:0] ip_dest,
                                       logic [31:0] ip_src, logic [47:0] mac_dst,
                                       logic [47:0] mac_src);
    flow_req_t r;
    r.op = OP_RECORD;
    r.ihl = ihl;
    r.ip_dest = ip_dest;
    r.ip_src = ip_src;
    r.mac_dst = mac_dst;
    r.mac_src = mac_src;
    r.read_index = 5'($urandom());
    return r;
  endfunction

  function automatic flow_req_t read_req(logic [4:0] idx);
    flow_req_t r;
    r = packet(4'($urandom()), $urandom(), $urandom(), rand48(), rand48());
    r.op = OP_READ;
    r.read_index = idx;
    return r;
  endfunction

  function automatic flow_req_t random_flow_item(int fresh_pct);
    flow_req_t r;
    int        pick;
    int        slot;
    logic [3:0] good_ihl;
    pick = $urandom_range(99);
    slot = (tbl_fill > 0) ? $urandom_range(tbl_fill - 1) : 0;
    good_ihl = 4'($urandom_range(15, 5));
    if (tbl_fill == 0 || pick < fresh_pct) begin
      r = packet(good_ihl, $urandom(), $urandom(), rand48(), rand48());
    end else if (pick < 50) begin
      r = packet(good_ihl, tbl_ip_dest[slot], tbl_ip_src[slot], rand48(), rand48());
    end else if (pick < 60) begin
      // Near miss: only one address bit differs from a stored flow.
      r = packet(good_ihl, tbl_ip_dest[slot], tbl_ip_src[slot], rand48(), rand48());
      if ($urandom_range(1)) r.ip_dest[$urandom_range(31)] ^= 1'b1;
      else r.ip_src[$urandom_range(31)] ^= 1'b1;
    end else if (pick < 78) begin
      r = read_req(5'($urandom()));
    end else if (pick < 90) begin
      r = packet(4'($urandom_range(4)), tbl_ip_dest[slot], tbl_ip_src[slot], rand48(),
                 rand48());
    end else begin
      r = packet(4'($urandom()), $urandom(), $urandom(), rand48(), rand48());
      r.op = op_t'($urandom_range(1));
    end
    return r;
  endfunction

  task automatic send_item(input flow_req_t r);
    int gap;
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      request_if.valid <= 1'b0;
      gap = $urandom_range(40, 1);
      repeat (gap) @(negedge clk);
    end
    request_if.operation <= r.op;
    request_if.mac_dst <= r.mac_dst;
    request_if.mac_src <= r.mac_src;
    request_if.header_length_words <= r.ihl;
    request_if.ip_dest <= r.ip_dest;
    request_if.ip_src <= r.ip_src;
    request_if.read_index <= r.read_index;
    request_if.valid <= 1'b1;
    do @(posedge clk); while (!request_if.ready);
    expected_results.push_back(predict_flow_result(r));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    request_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && response_if.valid && response_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("Result item arrived with nothing expected, status %0d",
               response_if.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", want.status, response_if.status);
        compare_field("entry_index", want.entry_index, response_if.entry_index);
        compare_field("packet_count", want.packet_count, response_if.packet_count);
        compare_field("entry_ip_dest", want.entry_ip_dest, response_if.entry_ip_dest);
        compare_field("entry_ip_src", want.entry_ip_src, response_if.entry_ip_src);
        compare_field("entry_mac_dst", want.entry_mac_dst, response_if.entry_mac_dst);
        compare_field("entry_mac_src", want.entry_mac_src, response_if.entry_mac_src);
        compare_field("entries_in_use", want.entries_in_use, response_if.entries_in_use);
        if (int'(want.status) < 6) status_seen[int'(want.status)]++;
      end
    end
  end

  initial begin
    response_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        response_if.ready <= 1'b0;
      end else if (sink_hold_cycles > 0) begin
        response_if.ready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        response_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic test_directed();
    send_item(read_req(5'd0));
    send_item(read_req(5'd31));
    send_item(packet(4'd0, 32'h0A00_0001, 32'h0A00_0002, 48'h1, 48'h2));
    send_item(packet(4'd4, '1, '1, '1, '1));
    send_item(packet(4'd5, '0, '0, '0, '0));
    send_item(packet(4'd15, '1, '1, '1, '1));
    send_item(packet(4'd5, '0, '0, '1, '1));
    send_item(packet(4'd7, '0, '1, 48'hA5A5_A5A5_A5A5, 48'h5A5A_5A5A_5A5A));
    send_item(packet(4'd9, '1, '0, 48'h0123_4567_89AB, 48'hBA98_7654_3210));
    send_item(read_req(5'd0));
    send_item(read_req(5'd3));
    send_item(read_req(5'd4));
    send_item(packet(4'd4, '1, '1, '0, '0));
    send_item(read_req(5'd1));
    send_item(packet(4'd15, '1, '1, 48'h0, 48'h0));
    send_item(packet(4'd6, 32'hA5A5_A5A5, 32'h5A5A_5A5A, rand48(), rand48()));
    send_item(packet(4'd5, 32'hA5A5_A5A5, 32'h5A5A_5A5A, rand48(), rand48()));
    send_item(read_req(5'd4));
    wait_drained();
  endtask

  task automatic test_partial_table();
    for (int n = 0; n < 290; n++) begin
      if (n == 120) sink_hold_cycles = 400;
      send_item(random_flow_item(5));
    end
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    while (tbl_fill < Entries) begin
      send_item(packet(4'($urandom_range(15, 5)), $urandom(), $urandom(), rand48(), rand48()));
      if ($urandom_range(3) == 0) send_item(read_req(5'($urandom())));
    end
    send_item(read_req(5'(Entries - 1)));
    send_item(packet(4'd5, $urandom(), $urandom(), rand48(), rand48()));
    send_item(packet(4'd15, tbl_ip_dest[Entries - 1], tbl_ip_src[Entries - 1], '0, '1));
    wait_drained();
  endtask

  task automatic test_full_table();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    for (int n = 0; n < 1000; n++) begin
      if (n == 250) begin
        src_idle_pct = 15;
        sink_idle_pct = 15;
      end
      if (n == 600) sink_hold_cycles = 500;
      if (n == 800) wait_drained();
      send_item(random_flow_item(10));
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    request_if.valid = 1'b0;
    request_if.operation = OP_RECORD;
    request_if.mac_dst = '0;
    request_if.mac_src = '0;
    request_if.header_length_words = '0;
    request_if.ip_dest = '0;
    request_if.ip_src = '0;
    request_if.read_index = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_partial_table();
    test_fill_to_full();
    test_full_table();

    repeat (2 * ItemCycles + 10) @(posedge clk);
    $display("Covered %0d items: %0d inserts, %0d hits, %0d bad headers, %0d full drops,",
             items_sent, status_seen[ST_INSERTED], status_seen[ST_HIT],
             status_seen[ST_BAD_HEADER], status_seen[ST_FULL]);
    $display("%0d reads of filled entries and %0d reads of unused entries.",
             status_seen[ST_READ_OK], status_seen[ST_READ_UNUSED]);
    if (errors == 0) begin
      $display("ip_pair_flow_counter_tb: done, clean");
    end else begin
      $display("ip_pair_flow_counter_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results still expected.", expected_results.size());
    $display("ip_pair_flow_counter_tb: done, errors");
    $finish;
  end

endmodule
